// File: sv/pcpa_pkg.sv
// shared widths, codes and types of the per-cpu page allocator
package pcpa_pkg;

    // field widths
    localparam int PAGE_W   = 15;
    localparam int TOP_W    = 16;
    localparam int CPU_ID_W = 3;
    localparam int STAT_W   = 2;
    localparam int CFG_AW   = 1;
    localparam int CFG_DW   = 16;

    // result status codes
    localparam logic [STAT_W-1:0] ST_ALLOC  = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FREED  = 2'd2;
    localparam logic [STAT_W-1:0] ST_REJECT = 2'd3;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_LOW_PAGE = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_TOP_PAGE = 1'b1;

    // one link word: does the page point on, and to which page
    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] page;
    } t_link;

endpackage

// File: sv/pcpa_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module pcpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/per_cpu_page_allocator_steal_core.sv
// per-cpu lifo page allocator with stealing from other cpus' lists
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------
//  in      | sink      | i_in_valid / o_in_stall | i_req_type, i_cpu_id, i_page_index
//  out     | source    | o_out_valid / i_out_stall | o_status, o_granted_page
//  cfg     | sink      | i_cfg_we               | i_cfg_addr, i_cfg_wdata
//
// one request at a time: a free passes through S_FREE and S_OUT; an allocate scans the lists in
// rotating order from its own, passing over each empty one, and pops the first head it finds in S_POP.
// the scan looks at one list head per cycle; a pop waits on the registered link ram read.
// the result sits in an output register; a stalled output holds the next result back.
// synchronous active-low reset empties every list; the link ram needs no clearing.
module per_cpu_page_allocator_steal_core #(
    parameter int NUM_CPUS  = 8,
    parameter int NUM_PAGES = 32768
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_req_type,
    input  logic [pcpa_pkg::CPU_ID_W-1:0] i_cpu_id,
    input  logic [pcpa_pkg::PAGE_W-1:0]   i_page_index,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pcpa_pkg::STAT_W-1:0]   o_status,
    output logic [pcpa_pkg::PAGE_W-1:0]   o_granted_page,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [pcpa_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [pcpa_pkg::CFG_DW-1:0]   i_cfg_wdata
);

    import pcpa_pkg::*;

    localparam int CW    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int DEPTH = (NUM_PAGES < 32768) ? NUM_PAGES : 32768;
    localparam int AW    = $clog2(DEPTH);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FREE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]          r_state, n_state;
    logic                r_req;
    logic [PAGE_W-1:0]   r_page;
    logic [CW-1:0]       r_scan, n_scan;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [STAT_W-1:0]   r_stat, n_stat;
    logic [PAGE_W-1:0]   r_gnt, n_gnt;
    logic [PAGE_W-1:0]   r_low;
    logic [TOP_W-1:0]    r_top;
    logic [PAGE_W-1:0]   r_head [NUM_CPUS];
    logic [NUM_CPUS-1:0] r_hvalid;
    logic                r_out_valid;
    logic [STAT_W-1:0]   r_out_stat;
    logic [PAGE_W-1:0]   r_out_page;

    logic                in_acc;
    logic                out_free;
    logic [4:0]          cpu_mod;
    logic [CW-1:0]       cpu_idx;
    logic [CW-1:0]       scan_inc;
    logic [PAGE_W-1:0]   cur_head;
    logic                cur_valid;
    logic                in_range;
    logic                ram_we;
    t_link               ram_wdata;
    t_link               ram_rdata;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // requesting cpu folded onto the cpus that exist
    always_comb begin
        cpu_mod = {2'b00, i_cpu_id};
        for (int k = 0; k < 8; k++) begin
            if (cpu_mod >= 5'(NUM_CPUS)) begin
                cpu_mod = cpu_mod - 5'(NUM_CPUS);
            end
        end
    end
    assign cpu_idx = cpu_mod[CW-1:0];

    // the list under examination and the next one in rotating order
    assign cur_head  = r_head[r_scan];
    assign cur_valid = r_hvalid[r_scan];
    assign scan_inc  = (r_scan == CW'(NUM_CPUS - 1)) ? '0 : r_scan + 1'b1;

    // range check of a freed page
    assign in_range = (r_page >= r_low) && ({1'b0, r_page} < r_top)
                   && (32'(r_page) < NUM_PAGES);

    // link write on an accepted free
    assign ram_we         = (r_state == S_FREE) && r_req && in_range;
    assign ram_wdata.valid = cur_valid;
    assign ram_wdata.page  = cur_head;

    pcpa_ram #(
        .WIDTH ($bits(t_link)),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_page[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (cur_head[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_scan  = r_scan;
        n_cnt   = r_cnt;
        n_stat  = r_stat;
        n_gnt   = r_gnt;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_scan  = cpu_idx;
                    n_cnt   = '0;
                    n_gnt   = '0;
                    n_state = i_req_type ? S_FREE : S_SCAN;
                end
            end
            S_FREE: begin
                n_stat  = in_range ? ST_FREED : ST_REJECT;
                n_state = S_OUT;
            end
            S_SCAN: begin
                if (cur_valid) begin
                    n_gnt   = cur_head;
                    n_state = S_POP;
                end else if (r_cnt == CW'(NUM_CPUS - 1)) begin
                    n_stat  = ST_EMPTY;
                    n_state = S_OUT;
                end else begin
                    n_scan = scan_inc;
                    n_cnt  = r_cnt + 1'b1;
                end
            end
            S_POP: begin
                n_stat  = ST_ALLOC;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hvalid    <= '0;
            r_out_valid <= 1'b0;
            r_low       <= '0;
            r_top       <= TOP_W'(32768);
        end else begin
            r_state <= n_state;
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_LOW_PAGE: r_low <= i_cfg_wdata[PAGE_W-1:0];
                    CFG_TOP_PAGE: r_top <= i_cfg_wdata[TOP_W-1:0];
                    default:      r_low <= r_low;
                endcase
            end
            // list head valid bits
            if (ram_we) begin
                r_hvalid[r_scan] <= 1'b1;
            end else if (r_state == S_POP) begin
                r_hvalid[r_scan] <= ram_rdata.valid;
            end
            // output register
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sequencer payload, list heads, request payload and output payload
    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
        r_cnt  <= n_cnt;
        r_stat <= n_stat;
        r_gnt  <= n_gnt;
        if (in_acc) begin
            r_req  <= i_req_type;
            r_page <= i_page_index;
        end
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CPUS; c++) begin
                r_head[c] <= '0;
            end
        end else if (ram_we) begin
            r_head[r_scan] <= r_page;
        end else if (r_state == S_POP) begin
            r_head[r_scan] <= ram_rdata.valid ? ram_rdata.page : '0;
        end
        if (r_state == S_OUT && out_free) begin
            r_out_stat <= r_stat;
            r_out_page <= (r_stat == ST_ALLOC) ? r_gnt : '0;
        end
    end

    assign o_in_stall     = !i_rst_n || (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_stat;
    assign o_granted_page = r_out_page;

endmodule

// File: sv/pcpa_chk.sv
// port-level checker for the per-cpu page allocator, bound to the top level
module pcpa_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [pcpa_pkg::STAT_W-1:0]   o_status,
    input logic [pcpa_pkg::PAGE_W-1:0]   o_granted_page
);

    import pcpa_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_status) && $stable(o_granted_page))
        else $error("result payload changed while stalled");

    // only a successful allocate carries a page
    a_gnt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_ALLOC |-> o_granted_page == '0)
        else $error("page shown on a result that is not an allocation");

    // a request keeps the block busy for the following cycles
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall ##1 o_in_stall)
        else $error("request taken while previous one still in work");

endmodule

bind per_cpu_page_allocator_steal_core pcpa_chk u_pcpa_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_granted_page (o_granted_page)
);
